[design/bre_pkg.sv]
// Shared types, constants and register codes for the battery runtime estimator.
// Used by bre_core and battery_runtime_estimator; depends on nothing.
`default_nettype none

package bre_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int RAW_W   = 8;
    localparam int PCT_W   = 7;
    localparam int RS_W    = 2;
    localparam int MIN_W   = 12;
    localparam int WIN_W   = 13;
    localparam int SPAN_W  = 7;

    // APB port
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // History depth default
    localparam int DEFAULT_HISTORY_DEPTH = 32;

    // Limits
    localparam int MAX_MINUTES = 1440;
    localparam int MAX_PERCENT = 100;
    // Largest whole-minute distance between two kept entries
    localparam int X_MAX = ((1 << WIN_W) - 1) / 60;

    // Register reset values
    localparam logic [WIN_W-1:0]  WINDOW_RESET   = 13'd1800;
    localparam logic [SPAN_W-1:0] MIN_SPAN_RESET = 7'd5;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PRESENT  = 2'd0;
    localparam logic [1:0] REG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_MIN_SPAN = 2'd2;

    // Read status codes
    localparam logic [RS_W-1:0] RS_OK      = 2'd0;
    localparam logic [RS_W-1:0] RS_MISSING = 2'd1;

    typedef struct packed {
        logic              present;
        logic [WIN_W-1:0]  window;
        logic [SPAN_W-1:0] min_span;
    } t_cfg;

    typedef struct packed {
        logic                    status_valid;
        logic [PCT_W-1:0]        percent;
        logic                    charging;
        logic                    estimate;
        logic signed [MIN_W-1:0] minutes;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_ctl;

    typedef enum logic [4:0] {
        S_IDLE,
        S_STORE,
        S_FILT_RD,
        S_FILT_CHK,
        S_EST,
        S_ACC_RD,
        S_ACC_X,
        S_ACC_XY,
        S_ACC_XX,
        S_F_NSXX,
        S_F_SXSX,
        S_F_NSXY,
        S_F_SXSY,
        S_F_CMP,
        S_F_SCALE,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[design/battery_runtime_estimator.sv]
// Battery runtime estimator: one status result per reading, from a timestamped
// charge reading, with time to full or empty over a bounded, windowed history.
// A reading is taken only while the block is idle. A reading that does not
// touch the history (battery absent, capacity missing or malformed) goes
// straight to its result. A good reading first stores and ages the history,
// then ends with one entry or a typical-rate estimate, or takes the two-point
// or the least-squares path. The history ring has one read port, so the
// least-squares sums visit the kept entries one at a time; the quotient comes
// from a restoring divider at one bit per cycle over a W-bit dividend (W is
// 39 bits at the default depth of 32). A result waiting on the output stalls
// the sequencer until it is taken.
// Results leave through an output register with valid/ready.
// Depends on bre_pkg and bre_core.
`default_nettype none

module battery_runtime_estimator #(
    parameter int HISTORY_DEPTH = bre_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // APB configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bre_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bre_pkg::APB_DW-1:0]  pwdata,
    output logic [bre_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    // readings
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [bre_pkg::TIME_W-1:0]  i_time_seconds,
    input  wire logic [bre_pkg::RAW_W-1:0]   i_raw_percent,
    input  wire logic                        i_on_charge,
    input  wire logic [bre_pkg::RS_W-1:0]    i_read_status,
    // results
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_status_valid,
    output logic [bre_pkg::PCT_W-1:0]        o_percent_now,
    output logic                             o_charging_now,
    output logic                             o_estimate_present,
    output logic signed [bre_pkg::MIN_W-1:0] o_minutes_left
);

    bre_pkg::t_cfg     r_cfg;
    bre_pkg::t_seq_ctl core_ctl;
    bre_pkg::t_result  core_res;
    bre_pkg::t_result  r_out;
    logic              r_out_valid;
    logic              load_out;
    logic              cfg_wr;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.present  <= 1'b0;
            r_cfg.window   <= bre_pkg::WINDOW_RESET;
            r_cfg.min_span <= bre_pkg::MIN_SPAN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bre_pkg::REG_PRESENT:  r_cfg.present  <= pwdata[0];
                bre_pkg::REG_WINDOW:   r_cfg.window   <= pwdata[bre_pkg::WIN_W-1:0];
                bre_pkg::REG_MIN_SPAN: r_cfg.min_span <= pwdata[bre_pkg::SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            bre_pkg::REG_PRESENT:  prdata = bre_pkg::APB_DW'(r_cfg.present);
            bre_pkg::REG_WINDOW:   prdata = bre_pkg::APB_DW'(r_cfg.window);
            bre_pkg::REG_MIN_SPAN: prdata = bre_pkg::APB_DW'(r_cfg.min_span);
            default:               prdata = '0;
        endcase
    end

    bre_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && o_in_ready),
        .i_time   (i_time_seconds),
        .i_raw    (i_raw_percent),
        .i_chg    (i_on_charge),
        .i_rs     (i_read_status),
        .i_cfg    (r_cfg),
        .i_take   (load_out),
        .o_ctl    (core_ctl),
        .o_result (core_res)
    );

    assign o_in_ready = core_ctl.idle;

    // Output register: loads when the slot is free or being emptied
    assign load_out = core_ctl.done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status_valid     = r_out.status_valid;
    assign o_percent_now      = r_out.percent;
    assign o_charging_now     = r_out.charging;
    assign o_estimate_present = r_out.estimate;
    assign o_minutes_left     = r_out.minutes;

`ifndef SYNTHESIS
    // a reading transfer always starts work, so the block is busy next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while sequencer busy");

    // minutes are -1 exactly when no estimate is flagged
    a_est_minutes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_estimate_present ? (o_minutes_left >= 0 &&
                         o_minutes_left <= 12'sd1440) : (o_minutes_left == -12'sd1)))
        else $error("estimate flag and minutes disagree");

    // percent stays clamped
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_percent_now <= 7'd100))
        else $error("percent out of range");
`endif

endmodule

`default_nettype wire

[design/bre_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the estimate paths.
// Depends on nothing outside this file.
`default_nettype none

module bre_div #(
    parameter int DW = 39,
    parameter int VW = 26
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);

    localparam int NW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [VW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   rem_sh;
    logic          fits;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
        fits   = rem_sh >= {1'b0, r_dvs};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

[design/bre_core.sv]
// Sequencer, history ring and arithmetic datapath of the runtime estimator.
// Depends on bre_pkg and bre_div.
`default_nettype none

module bre_core #(
    parameter int HISTORY_DEPTH = bre_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bre_pkg::TIME_W-1:0]  i_time,
    input  wire logic [bre_pkg::RAW_W-1:0]   i_raw,
    input  wire logic                        i_chg,
    input  wire logic [bre_pkg::RS_W-1:0]    i_rs,
    input  wire bre_pkg::t_cfg               i_cfg,
    input  wire logic                        i_take,
    output bre_pkg::t_seq_ctl                o_ctl,
    output bre_pkg::t_result                 o_result
);

    localparam int TW  = bre_pkg::TIME_W;
    localparam int PW7 = bre_pkg::PCT_W;
    localparam int IW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int XW  = $clog2(bre_pkg::X_MAX + 1);
    localparam int SXW = $clog2(HISTORY_DEPTH * bre_pkg::X_MAX + 1);
    localparam int BW  = 2 * SXW;
    localparam int PW  = 3 * SXW;
    localparam int WW  = bre_pkg::WIN_W;
    // floor(d / 60) = (d * 8739) >> 19 for every d below 2^13
    localparam int D60_MW = 14;
    localparam int D60_S  = 19;
    localparam logic [D60_MW-1:0] D60_M = 14'd8739;
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    // ring index helpers
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(HISTORY_DEPTH)) begin
            s = s - (CW+1)'(HISTORY_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [XW-1:0] div60(input logic [WW-1:0] d);
        logic [WW+D60_MW-1:0] m;
        m = (WW+D60_MW)'(d) * (WW+D60_MW)'(D60_M);
        return m[D60_S +: XW];
    endfunction

    function automatic logic [bre_pkg::RAW_W-1:0] RAW_MAX();
        return bre_pkg::RAW_W'(bre_pkg::MAX_PERCENT);
    endfunction

    bre_pkg::t_state r_state, n_state;

    // history ring
    logic [PW7+TW-1:0] mem [HISTORY_DEPTH];
    logic [PW7+TW-1:0] r_rd_data;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_raddr;

    // control registers
    logic [IW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    bre_pkg::t_result  r_res;

    // payload registers
    logic [TW-1:0]     r_time;
    logic [PW7-1:0]    r_pct;
    logic              r_chg;
    logic [TW-1:0]     r_last_time;
    logic [TW-1:0]     r_old_time;
    logic [PW7-1:0]    r_old_pct;
    logic [CW-1:0]     r_idx;
    logic [XW-1:0]     r_x;
    logic [PW7-1:0]    r_y;
    logic [SXW-1:0]    r_sx;
    logic [SXW-1:0]    r_sy;
    logic [BW-1:0]     r_sxy;
    logic [BW-1:0]     r_sxx;
    logic [BW-1:0]     r_t1;
    logic [BW-1:0]     r_den;
    logic [BW-1:0]     r_mag;
    logic              r_ls;

    // combinational
    logic [TW-1:0]     rd_time;
    logic [PW7-1:0]    rd_pct;
    logic [PW7-1:0]    clamp_pct;
    logic              back;
    logic [CW-1:0]     st_count0;
    logic              full;
    logic [IW-1:0]     st_head;
    logic [CW-1:0]     st_count;
    logic              too_old;
    logic [TW-1:0]     span_diff;
    logic [XW-1:0]     span;
    logic [XW-1:0]     acc_x;
    logic [TW-1:0]     acc_diff;
    logic signed [PW7+1:0] dp;
    logic signed [PW7+1:0] mag2;
    logic [10:0]       typ;
    logic [SXW-1:0]    mul_a;
    logic [BW-1:0]     mul_b;
    logic [PW-1:0]     prod;
    logic signed [BW:0] diff_w;
    logic signed [BW:0] magv;
    logic              cmp_ok;
    logic              last_entry;
    logic              div_start;
    logic              div_done;
    logic [PW-1:0]     div_quot;
    logic [bre_pkg::MIN_W-1:0] div_min;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= {r_pct, r_time};
        end
        r_rd_data <= mem[mem_raddr];
    end

    // Shared divider
    bre_div #(
        .DW (PW),
        .VW (BW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_divisor  (r_mag),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Datapath decode
    always_comb begin
        rd_time   = r_rd_data[TW-1:0];
        rd_pct    = r_rd_data[TW +: PW7];
        clamp_pct = (i_raw > RAW_MAX()) ? PW7'(bre_pkg::MAX_PERCENT) : i_raw[PW7-1:0];

        back      = (r_count != '0) && (r_time < r_last_time);
        st_count0 = back ? '0 : r_count;
        full      = st_count0 == DEPTH_C;
        st_head   = full ? wrap_add(r_head, CW'(1)) : r_head;
        st_count  = full ? (DEPTH_C - CW'(1)) : st_count0;

        too_old   = ({1'b0, rd_time} + (TW+1)'(i_cfg.window)) < {1'b0, r_time};

        span_diff = r_time - r_old_time;
        span      = div60(span_diff[WW-1:0]);
        acc_diff  = rd_time - r_old_time;
        acc_x     = div60(acc_diff[WW-1:0]);

        dp   = $signed({2'b00, r_pct}) - $signed({2'b00, r_old_pct});
        mag2 = r_chg ? dp : -dp;

        typ = r_chg ? ((11'(bre_pkg::MAX_PERCENT) - 11'(r_pct)) * 11'd3)
                    : (11'(r_pct) * 11'd12);

        prod   = PW'(mul_a) * PW'(mul_b);
        diff_w = $signed({1'b0, r_t1}) - $signed({1'b0, prod[BW-1:0]});
        magv   = r_chg ? diff_w : -diff_w;
        cmp_ok = prod > PW'(r_den);

        last_entry = (r_idx + CW'(1)) == r_count;

        div_min = (div_quot > PW'(bre_pkg::MAX_MINUTES))
                  ? bre_pkg::MIN_W'(bre_pkg::MAX_MINUTES)
                  : div_quot[bre_pkg::MIN_W-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bre_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_cfg.present && i_rs == bre_pkg::RS_OK)
                              ? bre_pkg::S_STORE : bre_pkg::S_DONE;
                end
            end
            bre_pkg::S_STORE:    n_state = bre_pkg::S_FILT_RD;
            bre_pkg::S_FILT_RD:  n_state = bre_pkg::S_FILT_CHK;
            bre_pkg::S_FILT_CHK: n_state = too_old ? bre_pkg::S_FILT_RD : bre_pkg::S_EST;
            bre_pkg::S_EST: begin
                if (r_count < CW'(2)) begin
                    n_state = bre_pkg::S_DONE;
                end else if (span < XW'(i_cfg.min_span)) begin
                    n_state = (span == '0 || mag2 <= 0) ? bre_pkg::S_DONE : bre_pkg::S_F_CMP;
                end else begin
                    n_state = bre_pkg::S_ACC_RD;
                end
            end
            bre_pkg::S_ACC_RD:  n_state = bre_pkg::S_ACC_X;
            bre_pkg::S_ACC_X:   n_state = bre_pkg::S_ACC_XY;
            bre_pkg::S_ACC_XY:  n_state = bre_pkg::S_ACC_XX;
            bre_pkg::S_ACC_XX:  n_state = last_entry ? bre_pkg::S_F_NSXX : bre_pkg::S_ACC_RD;
            bre_pkg::S_F_NSXX:  n_state = bre_pkg::S_F_SXSX;
            bre_pkg::S_F_SXSX:  n_state = (diff_w > 0) ? bre_pkg::S_F_NSXY : bre_pkg::S_DONE;
            bre_pkg::S_F_NSXY:  n_state = bre_pkg::S_F_SXSY;
            bre_pkg::S_F_SXSY:  n_state = (magv > 0) ? bre_pkg::S_F_CMP : bre_pkg::S_DONE;
            bre_pkg::S_F_CMP:   n_state = cmp_ok ? bre_pkg::S_F_SCALE : bre_pkg::S_DONE;
            bre_pkg::S_F_SCALE: n_state = bre_pkg::S_DIV;
            bre_pkg::S_DIV:     n_state = div_done ? bre_pkg::S_DONE : bre_pkg::S_DIV;
            bre_pkg::S_DONE:    n_state = i_take ? bre_pkg::S_IDLE : bre_pkg::S_DONE;
            default:            n_state = bre_pkg::S_IDLE;
        endcase
    end

    // Control outputs: memory ports, multiplier operands, divider start
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wrap_add(st_head, st_count);
        mem_raddr = r_head;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            bre_pkg::S_STORE:  mem_we = 1'b1;
            bre_pkg::S_ACC_RD: mem_raddr = wrap_add(r_head, r_idx);
            bre_pkg::S_ACC_XY: begin
                mul_a = SXW'(r_x);
                mul_b = BW'(r_y);
            end
            bre_pkg::S_ACC_XX: begin
                mul_a = SXW'(r_x);
                mul_b = BW'(r_x);
            end
            bre_pkg::S_F_NSXX: begin
                mul_a = SXW'(r_count);
                mul_b = r_sxx;
            end
            bre_pkg::S_F_SXSX: begin
                mul_a = r_sx;
                mul_b = BW'(r_sx);
            end
            bre_pkg::S_F_NSXY: begin
                mul_a = SXW'(r_count);
                mul_b = r_sxy;
            end
            bre_pkg::S_F_SXSY: begin
                mul_a = r_sx;
                mul_b = BW'(r_sy);
            end
            bre_pkg::S_F_CMP: begin
                mul_a = SXW'(bre_pkg::MAX_PERCENT);
                mul_b = r_mag;
            end
            bre_pkg::S_F_SCALE: begin
                mul_a = r_chg ? SXW'(PW7'(bre_pkg::MAX_PERCENT) - r_pct) : SXW'(r_pct);
                mul_b = r_den;
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // State, ring pointers and held status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bre_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_res   <= '{status_valid: 1'b0, percent: '0, charging: 1'b0,
                         estimate: 1'b0, minutes: '1};
        end else begin
            r_state <= n_state;
            case (r_state)
                bre_pkg::S_IDLE: begin
                    if (i_start && i_cfg.present) begin
                        if (i_rs == bre_pkg::RS_OK) begin
                            r_res <= '{status_valid: 1'b1, percent: clamp_pct,
                                       charging: i_chg, estimate: 1'b0, minutes: '1};
                        end else if (i_rs == bre_pkg::RS_MISSING) begin
                            r_res.status_valid <= 1'b0;
                        end else begin
                            r_res <= '{status_valid: 1'b0, percent: '0, charging: 1'b0,
                                       estimate: 1'b0, minutes: '1};
                        end
                    end
                end
                bre_pkg::S_STORE: begin
                    r_head  <= st_head;
                    r_count <= st_count + CW'(1);
                end
                bre_pkg::S_FILT_CHK: begin
                    // drop entries that fell out of the window
                    if (too_old) begin
                        r_head  <= wrap_add(r_head, CW'(1));
                        r_count <= r_count - CW'(1);
                    end
                end
                bre_pkg::S_EST: begin
                    // typical rates: lone entry, zero span, flat/reversed two-point rate
                    if (r_count < CW'(2) ||
                        (span < XW'(i_cfg.min_span) && (span == '0 || mag2 <= 0))) begin
                        r_res.estimate <= 1'b1;
                        r_res.minutes  <= bre_pkg::MIN_W'(typ);
                    end
                end
                bre_pkg::S_F_CMP: begin
                    if (!cmp_ok && !r_ls) begin
                        r_res.estimate <= 1'b1;
                        r_res.minutes  <= bre_pkg::MIN_W'(typ);
                    end
                end
                bre_pkg::S_DIV: begin
                    if (div_done) begin
                        r_res.estimate <= 1'b1;
                        r_res.minutes  <= div_min;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            bre_pkg::S_IDLE: begin
                r_time <= i_time;
                r_pct  <= clamp_pct;
                r_chg  <= i_chg;
            end
            bre_pkg::S_STORE: r_last_time <= r_time;
            bre_pkg::S_FILT_CHK: begin
                r_old_time <= rd_time;
                r_old_pct  <= rd_pct;
            end
            bre_pkg::S_EST: begin
                r_idx <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxy <= '0;
                r_sxx <= '0;
                r_ls  <= !(span < XW'(i_cfg.min_span));
                r_den <= BW'(span);
                r_mag <= BW'(unsigned'(mag2[PW7:0]));
            end
            bre_pkg::S_ACC_X: begin
                r_x <= acc_x;
                r_y <= rd_pct;
            end
            bre_pkg::S_ACC_XY: begin
                r_sxy <= r_sxy + prod[BW-1:0];
                r_sx  <= r_sx + SXW'(r_x);
                r_sy  <= r_sy + SXW'(r_y);
            end
            bre_pkg::S_ACC_XX: begin
                r_sxx <= r_sxx + prod[BW-1:0];
                r_idx <= r_idx + CW'(1);
            end
            bre_pkg::S_F_NSXX: r_t1 <= prod[BW-1:0];
            bre_pkg::S_F_SXSX: r_den <= diff_w[BW-1:0];
            bre_pkg::S_F_NSXY: r_t1 <= prod[BW-1:0];
            bre_pkg::S_F_SXSY: r_mag <= magv[BW-1:0];
            default: begin
            end
        endcase
    end

    assign o_ctl.idle = (r_state == bre_pkg::S_IDLE);
    assign o_ctl.done = (r_state == bre_pkg::S_DONE);
    assign o_result   = r_res;

endmodule

`default_nettype wire
